/* sv/ftbc_pkg.sv */
// shared types and constants for the fractional tick bcd clock
package ftbc_pkg;

    // configuration register indexes
    localparam logic CFG_TICK_INCREMENT = 1'b0;
    localparam logic CFG_SECOND_PERIOD  = 1'b1;

    localparam int INC_W    = 12;
    localparam int PERIOD_W = 16;
    localparam int ACC_W    = 17;
    localparam int CFG_W    = 16;

    localparam logic [INC_W-1:0]    INC_RESET    = 12'd256;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1953;
    localparam logic [ACC_W-1:0]    ACC_MAX      = 17'h1FFFF;

    localparam logic [3:0] UNITS_LAST = 4'd9;
    localparam logic [2:0] TENS_LAST  = 3'd5;
    localparam logic [1:0] HR_TENS_LAST  = 2'd2;
    localparam logic [3:0] HR_UNITS_LAST = 4'd3;
    localparam logic [3:0] HR_UNITS_RESET = 4'd8;

    typedef struct packed {
        logic [1:0] hr_tens;
        logic [3:0] hr_units;
        logic [2:0] min_tens;
        logic [3:0] min_units;
        logic [2:0] sec_tens;
        logic [3:0] sec_units;
    } t_time;

    // 08:00:00
    localparam t_time TIME_RESET = '{hr_tens: 2'd0, hr_units: HR_UNITS_RESET,
                                     min_tens: 3'd0, min_units: 4'd0,
                                     sec_tens: 3'd0, sec_units: 4'd0};

    typedef struct packed {
        t_time tod;
        logic  led;
        logic  pulse;
    } t_result;

endpackage

/* sv/ftbc_time_adv.sv */
// bcd time of day advance by one second with day wrap
module ftbc_time_adv (
    input  ftbc_pkg::t_time i_time,
    output ftbc_pkg::t_time o_time
);

    always_comb begin
        o_time = i_time;
        if (i_time.sec_units < ftbc_pkg::UNITS_LAST) begin
            o_time.sec_units = i_time.sec_units + 4'd1;
        end else begin
            o_time.sec_units = '0;
            if (i_time.sec_tens < ftbc_pkg::TENS_LAST) begin
                o_time.sec_tens = i_time.sec_tens + 3'd1;
            end else begin
                o_time.sec_tens = '0;
                if (i_time.min_units < ftbc_pkg::UNITS_LAST) begin
                    o_time.min_units = i_time.min_units + 4'd1;
                end else begin
                    o_time.min_units = '0;
                    if (i_time.min_tens < ftbc_pkg::TENS_LAST) begin
                        o_time.min_tens = i_time.min_tens + 3'd1;
                    end else begin
                        o_time.min_tens = '0;
                        // end of day
                        if (i_time.hr_tens >= ftbc_pkg::HR_TENS_LAST &&
                            i_time.hr_units >= ftbc_pkg::HR_UNITS_LAST) begin
                            o_time.hr_tens  = '0;
                            o_time.hr_units = '0;
                        end else if (i_time.hr_units < ftbc_pkg::UNITS_LAST) begin
                            o_time.hr_units = i_time.hr_units + 4'd1;
                        end else begin
                            o_time.hr_units = '0;
                            o_time.hr_tens  = i_time.hr_tens + 2'd1;
                        end
                    end
                end
            end
        end
    end

endmodule

/* sv/fractional_tick_bcd_clock.sv */
// top level of the fractional tick bcd time of day clock
// One tick request is taken per clock while input ready is high; its result
// is registered in the result register, or in the skid entry when the output
// is held. The whole update (saturating accumulator add, compare with the
// period, subtract, bcd carry chain) sits between the state registers and a
// result register. A two-entry output (result register plus skid entry) lets
// one more request be taken after the output side stalls; input ready drops
// only once both are full. The time of day resets to 08:00:00, led flag set.
module fractional_tick_bcd_clock (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // tick requests
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_overflow,
    // time results
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_hours_tens,
    output logic [3:0] o_hours_units,
    output logic [2:0] o_minutes_tens,
    output logic [3:0] o_minutes_units,
    output logic [2:0] o_seconds_tens,
    output logic [3:0] o_seconds_units,
    output logic       o_led_level,
    output logic       o_second_pulse
);

    // configuration
    logic [ftbc_pkg::INC_W-1:0]    r_tick_inc;
    logic [ftbc_pkg::PERIOD_W-1:0] r_period;

    // clock state
    logic [ftbc_pkg::ACC_W-1:0] r_acc, n_acc;
    ftbc_pkg::t_time            r_time, n_time;
    logic                       r_blink, n_blink;

    // output register and skid entry
    ftbc_pkg::t_result r_out, r_skid, n_res;
    logic              r_out_valid, r_skid_valid;

    logic [ftbc_pkg::ACC_W:0]   sum;
    logic [ftbc_pkg::ACC_W-1:0] acc_add;
    logic                       second;
    ftbc_pkg::t_time            adv_time;
    logic                       in_acc, out_pop;

    assign o_in_ready = !r_skid_valid;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_pop    = r_out_valid && i_out_ready;

    ftbc_time_adv u_adv (
        .i_time (r_time),
        .o_time (adv_time)
    );

    // accumulator step: add on overflow with saturation, then take one period
    always_comb begin
        sum     = {1'b0, r_acc} + {{(ftbc_pkg::ACC_W + 1 - ftbc_pkg::INC_W){1'b0}}, r_tick_inc};
        acc_add = r_acc;
        if (i_overflow) begin
            acc_add = sum[ftbc_pkg::ACC_W] ? ftbc_pkg::ACC_MAX : sum[ftbc_pkg::ACC_W-1:0];
        end
        second = acc_add >= {{(ftbc_pkg::ACC_W - ftbc_pkg::PERIOD_W){1'b0}}, r_period};
        n_acc  = acc_add;
        if (second) begin
            n_acc = acc_add - {{(ftbc_pkg::ACC_W - ftbc_pkg::PERIOD_W){1'b0}}, r_period};
        end
        n_time  = second ? adv_time : r_time;
        n_blink = r_blink ^ second;
        n_res.tod   = n_time;
        n_res.led   = n_blink;
        n_res.pulse = second;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_inc <= ftbc_pkg::INC_RESET;
            r_period   <= ftbc_pkg::PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ftbc_pkg::CFG_TICK_INCREMENT: r_tick_inc <= i_cfg_data[ftbc_pkg::INC_W-1:0];
                ftbc_pkg::CFG_SECOND_PERIOD:  r_period   <= i_cfg_data[ftbc_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // clock state, updated once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_time  <= ftbc_pkg::TIME_RESET;
            r_blink <= 1'b1;
        end else if (in_acc) begin
            r_acc   <= n_acc;
            r_time  <= n_time;
            r_blink <= n_blink;
        end
    end

    // output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc) begin
            // new result lands in skid only when the output is held
            if (r_out_valid && !i_out_ready) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (in_acc) begin
            if (r_out_valid && !i_out_ready) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hours_tens    = r_out.tod.hr_tens;
    assign o_hours_units   = r_out.tod.hr_units;
    assign o_minutes_tens  = r_out.tod.min_tens;
    assign o_minutes_units = r_out.tod.min_units;
    assign o_seconds_tens  = r_out.tod.sec_tens;
    assign o_seconds_units = r_out.tod.sec_units;
    assign o_led_level     = r_out.led;
    assign o_second_pulse  = r_out.pulse;

`ifndef NO_ASSERTIONS
    // skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without output valid");

    // clock state moves only on an accepted request
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_acc) && $stable(r_time) && $stable(r_blink))
        else $error("clock state changed without a request");

    // the led flag toggles exactly when a second elapses
    a_blink_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_blink != $past(r_blink)) == $past(second))
        else $error("led flag out of step with second pulse");

    // accumulated remainder stays below the period unless saturation grows it
    a_acc_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && second && r_tick_inc <= r_period && r_acc < {1'b0, r_period})
        |=> r_acc < {1'b0, $past(r_period)})
        else $error("accumulator remainder not below period");
`endif

endmodule

/* tb/sv/fractional_tick_bcd_clock_tb.sv */
// testbench for the fractional tick bcd time of day clock
`timescale 1ns / 100ps

module fractional_tick_bcd_clock_tb;

    // a correct run never goes this long without a request or a result moving
    localparam int QUIET_LIMIT = 2000;
    localparam int REPORT_MAX  = 40;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    // one line of the directed table: a register write or a tick request
    typedef struct packed {
        t_row_kind                  kind;
        logic                       idx;
        logic [ftbc_pkg::CFG_W-1:0] data;
        logic                       ovf;
        logic                       typed;
        ftbc_pkg::t_result          want;
    } t_row;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic                       i_cfg_index = ftbc_pkg::CFG_TICK_INCREMENT;
    logic [ftbc_pkg::CFG_W-1:0] i_cfg_data  = '0;
    logic                       i_in_valid  = 1'b0;
    logic                       i_overflow  = 1'b0;
    logic                       i_out_ready = 1'b0;
    logic                       o_in_ready;
    logic                       o_out_valid;
    logic [1:0]                 o_hours_tens;
    logic [3:0]                 o_hours_units;
    logic [2:0]                 o_minutes_tens;
    logic [3:0]                 o_minutes_units;
    logic [2:0]                 o_seconds_tens;
    logic [3:0]                 o_seconds_units;
    logic                       o_led_level;
    logic                       o_second_pulse;

    // predicted clock state and register copies
    logic [ftbc_pkg::INC_W-1:0]    tick_inc;
    logic [ftbc_pkg::PERIOD_W-1:0] sec_period;
    logic [ftbc_pkg::ACC_W-1:0]    frac_acc;
    ftbc_pkg::t_time               tod_now;
    logic                          led_now;

    ftbc_pkg::t_result tod_expected[$];
    t_row              script[$];

    // typed expectation handed from the driver to the monitor
    logic              row_typed = 1'b0;
    ftbc_pkg::t_result row_want  = '0;

    int          send_idle_pct  = 34;
    int          recv_stall_pct = 58;
    int unsigned ticks_taken    = 0;
    int unsigned results_seen   = 0;
    int unsigned seconds_seen   = 0;
    int unsigned day_wraps      = 0;
    int unsigned ceiling_hits   = 0;
    int unsigned reg_writes     = 0;
    int unsigned errors         = 0;
    int unsigned quiet          = 0;

    fractional_tick_bcd_clock DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_overflow      (i_overflow),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_hours_tens    (o_hours_tens),
        .o_hours_units   (o_hours_units),
        .o_minutes_tens  (o_minutes_tens),
        .o_minutes_units (o_minutes_units),
        .o_seconds_tens  (o_seconds_tens),
        .o_seconds_units (o_seconds_units),
        .o_led_level     (o_led_level),
        .o_second_pulse  (o_second_pulse)
    );

    always #6 i_clk = ~i_clk;

    // one tick of the clock: saturating add on overflow, at most one second
    // per tick, then the bcd carry chain with the 23:59:59 wrap
    function automatic ftbc_pkg::t_result predict_tick(input logic ovf);
        logic [ftbc_pkg::ACC_W:0] sum;
        logic                     pulse;
        ftbc_pkg::t_result        r;
        pulse = 1'b0;
        if (ovf) begin
            sum = {1'b0, frac_acc}
                + {{(ftbc_pkg::ACC_W + 1 - ftbc_pkg::INC_W){1'b0}}, tick_inc};
            if (sum[ftbc_pkg::ACC_W]) begin
                frac_acc = ftbc_pkg::ACC_MAX;
                ceiling_hits++;
            end else begin
                frac_acc = sum[ftbc_pkg::ACC_W-1:0];
            end
        end
        if (frac_acc >= {1'b0, sec_period}) begin
            frac_acc = frac_acc - {1'b0, sec_period};
            pulse    = 1'b1;
            led_now  = ~led_now;
            seconds_seen++;
            if (tod_now.sec_units < ftbc_pkg::UNITS_LAST) begin
                tod_now.sec_units = tod_now.sec_units + 4'd1;
            end else begin
                tod_now.sec_units = '0;
                if (tod_now.sec_tens < ftbc_pkg::TENS_LAST) begin
                    tod_now.sec_tens = tod_now.sec_tens + 3'd1;
                end else begin
                    tod_now.sec_tens = '0;
                    if (tod_now.min_units < ftbc_pkg::UNITS_LAST) begin
                        tod_now.min_units = tod_now.min_units + 4'd1;
                    end else begin
                        tod_now.min_units = '0;
                        if (tod_now.min_tens < ftbc_pkg::TENS_LAST) begin
                            tod_now.min_tens = tod_now.min_tens + 3'd1;
                        end else begin
                            tod_now.min_tens = '0;
                            // 23 o'clock rolls over to midnight
                            if (tod_now.hr_tens >= ftbc_pkg::HR_TENS_LAST &&
                                tod_now.hr_units >= ftbc_pkg::HR_UNITS_LAST) begin
                                tod_now.hr_tens  = '0;
                                tod_now.hr_units = '0;
                                day_wraps++;
                            end else if (tod_now.hr_units < ftbc_pkg::UNITS_LAST) begin
                                tod_now.hr_units = tod_now.hr_units + 4'd1;
                            end else begin
                                tod_now.hr_units = '0;
                                tod_now.hr_tens  = tod_now.hr_tens + 2'd1;
                            end
                        end
                    end
                end
            end
        end
        r.tod   = tod_now;
        r.led   = led_now;
        r.pulse = pulse;
        return r;
    endfunction

    function automatic ftbc_pkg::t_result face(input int ht, input int hu, input int mt,
                                               input int mu, input int st, input int su,
                                               input int led, input int pulse);
        ftbc_pkg::t_result r;
        r.tod.hr_tens   = 2'(ht);
        r.tod.hr_units  = 4'(hu);
        r.tod.min_tens  = 3'(mt);
        r.tod.min_units = 4'(mu);
        r.tod.sec_tens  = 3'(st);
        r.tod.sec_units = 4'(su);
        r.led           = 1'(led);
        r.pulse         = 1'(pulse);
        return r;
    endfunction

    function automatic t_row tick_row(input logic ovf, input logic typed,
                                      input ftbc_pkg::t_result want);
        t_row r;
        r       = '0;
        r.kind  = ROW_TICK;
        r.ovf   = ovf;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic idx, input logic [ftbc_pkg::CFG_W-1:0] data);
        t_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [3:0] exp_v,
                               input logic [3:0] got_v);
        if (got_v !== exp_v) begin
            errors++;
            if (errors <= REPORT_MAX)
                $display("%0t ns: result %0d, %s expected %0d, got %0d",
                         $realtime, results_seen, name, exp_v, got_v);
            else if (errors == REPORT_MAX + 1)
                $display("%0t ns: further mismatches not shown", $realtime);
        end
    endtask

    // monitor: register copies, predictor, result check and watchdog, all on
    // values sampled at the rising edge
    always @(posedge i_clk) begin : monitor
        ftbc_pkg::t_result got;
        ftbc_pkg::t_result want;
        logic              moved;
        if (!i_rst_n) begin
            tick_inc   = ftbc_pkg::INC_RESET;
            sec_period = ftbc_pkg::PERIOD_RESET;
            frac_acc   = '0;
            tod_now    = ftbc_pkg::TIME_RESET;
            led_now    = 1'b1;
            quiet      = 0;
        end else begin
            moved = 1'b0;
            if (i_cfg_we) begin
                // the increment register keeps only its low bits
                if (i_cfg_index == ftbc_pkg::CFG_TICK_INCREMENT)
                    tick_inc = i_cfg_data[ftbc_pkg::INC_W-1:0];
                else
                    sec_period = i_cfg_data[ftbc_pkg::PERIOD_W-1:0];
            end
            // results leave before a request accepted on the same edge is queued
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                got = {o_hours_tens, o_hours_units, o_minutes_tens, o_minutes_units,
                       o_seconds_tens, o_seconds_units, o_led_level, o_second_pulse};
                if (tod_expected.size() == 0) begin
                    errors++;
                    $display("%0t ns: result with no request pending, got %0d%0d:%0d%0d:%0d%0d",
                             $realtime, got.tod.hr_tens, got.tod.hr_units, got.tod.min_tens,
                             got.tod.min_units, got.tod.sec_tens, got.tod.sec_units);
                end else begin
                    want = tod_expected.pop_front();
                    check_field("hours_tens", 4'(want.tod.hr_tens), 4'(got.tod.hr_tens));
                    check_field("hours_units", want.tod.hr_units, got.tod.hr_units);
                    check_field("minutes_tens", 4'(want.tod.min_tens), 4'(got.tod.min_tens));
                    check_field("minutes_units", want.tod.min_units, got.tod.min_units);
                    check_field("seconds_tens", 4'(want.tod.sec_tens), 4'(got.tod.sec_tens));
                    check_field("seconds_units", want.tod.sec_units, got.tod.sec_units);
                    check_field("led_level", 4'(want.led), 4'(got.led));
                    check_field("second_pulse", 4'(want.pulse), 4'(got.pulse));
                end
                results_seen++;
            end
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                want = predict_tick(i_overflow);
                // directed rows with a hand-written answer override the predictor
                if (row_typed)
                    want = row_want;
                tod_expected.push_back(want);
                ticks_taken++;
            end
            quiet = moved ? 0 : quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t ns: no traffic for %0d cycles, %0d results outstanding",
                         $realtime, QUIET_LIMIT, tod_expected.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // receiver: random back-pressure at the rate of the current phase
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // one tick request, preceded by random sender gaps; valid stays high on
    // return so the next request can follow without a bubble
    task automatic push_tick(input logic ovf, input logic typed,
                             input ftbc_pkg::t_result want);
        int unsigned seen;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_overflow <= ovf;
        row_typed  = typed;
        row_want   = want;
        seen       = ticks_taken;
        do @(negedge i_clk); while (ticks_taken == seen);
    endtask

    // registers change only with the clock idle: every result is back
    task automatic set_reg(input logic idx, input logic [ftbc_pkg::CFG_W-1:0] data);
        i_in_valid <= 1'b0;
        while (tod_expected.size() != 0)
            @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        reg_writes++;
    endtask

    // one setting and a run of random ticks under it; the increment write
    // carries junk in the bits above the register
    task automatic run_setting(input int unsigned inc, input int unsigned period,
                               input int n, input int ovf_pct);
        set_reg(ftbc_pkg::CFG_TICK_INCREMENT, {4'($urandom_range(15)), 12'(inc)});
        set_reg(ftbc_pkg::CFG_SECOND_PERIOD, 16'(period));
        repeat (n)
            push_tick($urandom_range(99) < ovf_pct, 1'b0, '0);
    endtask

    task automatic random_block();
        int unsigned inc_v;
        // near the reset rate, a second every eight overflows or so
        run_setting(ftbc_pkg::INC_RESET, ftbc_pkg::PERIOD_RESET, 50, 90);
        // random setting with a second every few ticks
        inc_v = $urandom_range(1, 4095);
        run_setting(inc_v, $urandom_range(0, 3 * inc_v), 70, $urandom_range(20, 100));
        // random setting over the whole period range, seconds mostly rare
        run_setting($urandom_range(0, 4095), $urandom_range(0, 65535), 25, 70);
        // fastest and slowest nonzero settings
        run_setting(4095, 1, 15, 50);
        run_setting(1, 1, 15, 50);
        run_setting(1, 65535, 10, 100);
        // zero period leaves the accumulator alone, so it climbs to its ceiling;
        // a long period with zero increment then shows where it stopped
        run_setting(4095, 0, 35, 100);
        run_setting(0, 65535, 8, 50);
    endtask

    initial begin : stimulus
        // directed table: reset state, zero period, zero increment, the
        // extremes, surplus carried over many ticks and the exact-period edge
        script.push_back(tick_row(1'b0, 1'b1, face(0, 8, 0, 0, 0, 0, 1, 0)));
        script.push_back(tick_row(1'b1, 1'b1, face(0, 8, 0, 0, 0, 0, 1, 0)));
        script.push_back(cfg_row(ftbc_pkg::CFG_SECOND_PERIOD, 16'd0));
        script.push_back(tick_row(1'b0, 1'b1, face(0, 8, 0, 0, 0, 1, 0, 1)));
        script.push_back(tick_row(1'b1, 1'b1, face(0, 8, 0, 0, 0, 2, 1, 1)));
        script.push_back(cfg_row(ftbc_pkg::CFG_TICK_INCREMENT, 16'd0));
        script.push_back(cfg_row(ftbc_pkg::CFG_SECOND_PERIOD, 16'hFFFF));
        script.push_back(tick_row(1'b1, 1'b1, face(0, 8, 0, 0, 0, 2, 1, 0)));
        script.push_back(cfg_row(ftbc_pkg::CFG_TICK_INCREMENT, 16'h0FFF));
        script.push_back(cfg_row(ftbc_pkg::CFG_SECOND_PERIOD, 16'd1));
        script.push_back(tick_row(1'b1, 1'b1, face(0, 8, 0, 0, 0, 3, 0, 1)));
        // surplus drains one second per tick, through the seconds tens carry
        repeat (8)
            script.push_back(tick_row(1'b0, 1'b0, '0));
        // high data bits dropped: increment becomes one
        script.push_back(cfg_row(ftbc_pkg::CFG_TICK_INCREMENT, 16'hF001));
        script.push_back(cfg_row(ftbc_pkg::CFG_SECOND_PERIOD, 16'd4600));
        // accumulator steps just below, then exactly onto the period
        repeat (2)
            script.push_back(tick_row(1'b1, 1'b0, '0));
        repeat (2)
            script.push_back(tick_row(1'b0, 1'b0, '0));

        // synchronous reset held low from time zero, then released
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // phase one: sender idle odds 34 percent, receiver stall odds 58 percent
        send_idle_pct  = 34;
        recv_stall_pct = 58;
        foreach (script[k]) begin
            if (script[k].kind == ROW_CFG)
                set_reg(script[k].idx, script[k].data);
            else
                push_tick(script[k].ovf, script[k].typed, script[k].want);
        end
        random_block();

        // phase two: the rates swapped
        send_idle_pct  = 58;
        recv_stall_pct = 34;
        random_block();

        // phase three: no idling on either side
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_block();

        // drain, then give a stray result time to show up
        i_in_valid <= 1'b0;
        while (tod_expected.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("covered %0d tick requests under %0d register writes, %0d seconds elapsed",
                 ticks_taken, reg_writes, seconds_seen);
        $display("midnight rollovers %0d, accumulator ceiling reached %0d times, %0d mismatches",
                 day_wraps, ceiling_hits, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
